[src/utf7_pkg.sv]
`default_nettype none

package utf7_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned UnitW = 16;
  localparam int unsigned SymW  = 6;
  localparam int unsigned StepW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CharW-1:0] LastCharReset   = 7'h2F;
  localparam logic [CharW-1:0] EscapeCharReset = 7'h2B;

  localparam logic [ByteW-1:0] DashChar  = 8'h2D;
  localparam logic [ByteW-1:0] PlusChar  = 8'h2B;
  localparam logic [ByteW-1:0] UpperA    = 8'h41;
  localparam logic [ByteW-1:0] UpperZ    = 8'h5A;
  localparam logic [ByteW-1:0] LowerA    = 8'h61;
  localparam logic [ByteW-1:0] LowerZ    = 8'h7A;
  localparam logic [ByteW-1:0] Digit0    = 8'h30;
  localparam logic [ByteW-1:0] Digit9    = 8'h39;

  localparam logic [SymW-1:0] LowerBase = 6'd26;
  localparam logic [SymW-1:0] DigitBase = 6'd52;
  localparam logic [SymW-1:0] PlusValue = 6'd62;
  localparam logic [SymW-1:0] LastValue = 6'd63;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAST_CHAR   = 1'b0,
    CFG_ESCAPE_CHAR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic            valid;
    logic [SymW-1:0] value;
  } sym_t;

endpackage

`default_nettype wire

[src/utf7_if.sv]
`default_nettype none

interface utf7_byte_if import utf7_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface utf7_unit_if import utf7_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

interface utf7_cfg_if import utf7_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CharW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/utf7_decoder_unit.sv]
// An accepted byte is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle unless a code unit waits untaken; the input register
// lets a new byte enter while a finished code unit waits in the result register.
// Reset: asynchronous, active low; returns to direct mode with last_char '/'
// and escape_char '+', and empties both registers.
`default_nettype none

module utf7_decoder_unit import utf7_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  utf7_cfg_if.sink    cfg_i,
  utf7_byte_if.sink   in_i,
  utf7_unit_if.source out_o
);

  logic [CharW-1:0] last_char_q, escape_char_q;
  logic             s0_valid_q, s0_valid_d;
  logic [ByteW-1:0] s0_byte_q;
  logic             in_b64_q, in_b64_d;
  logic             fresh_q, fresh_d;
  logic [StepW-1:0] step_q, step_d;
  logic [UnitW-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [UnitW-1:0] out_unit_q;

  sym_t             sym;
  logic             fire;
  logic             in_accept;
  logic             emit;
  logic             take_direct;
  logic [UnitW-1:0] unit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_char_q   <= LastCharReset;
      escape_char_q <= EscapeCharReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_LAST_CHAR:   last_char_q   <= cfg_i.data;
        CFG_ESCAPE_CHAR: escape_char_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign fire        = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s0_valid_q || fire;
  assign in_accept   = in_i.valid && in_i.ready;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_accept) begin
      s0_valid_d = 1'b1;
    end else if (fire) begin
      s0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_byte_q <= in_i.in_byte;
    end
  end

  utf7_symbol_lookup u_symbol_lookup (
    .byte_i      (s0_byte_q),
    .last_char_i (last_char_q),
    .sym_o       (sym)
  );

  always_comb begin
    in_b64_d    = in_b64_q;
    fresh_d     = fresh_q;
    step_d      = step_q;
    acc_d       = acc_q;
    emit        = 1'b0;
    unit        = '0;
    take_direct = 1'b0;
    if (!in_b64_q) begin
      take_direct = 1'b1;
    end else if (fresh_q && s0_byte_q == DashChar) begin
      emit     = 1'b1;
      unit     = {{(UnitW-CharW){1'b0}}, escape_char_q};
      in_b64_d = 1'b0;
      fresh_d  = 1'b0;
    end else begin
      fresh_d = 1'b0;
      if (!sym.valid) begin
        // A dash ends the run silently; any other byte is then decoded directly.
        in_b64_d    = 1'b0;
        take_direct = (s0_byte_q != DashChar);
      end else begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: acc_d = {sym.value, 10'h000};
          3'd1: acc_d = acc_q + {6'h00, sym.value, 4'h0};
          3'd2: begin
            emit  = 1'b1;
            unit  = acc_q + {12'h000, sym.value[5:2]};
            acc_d = {sym.value[1:0], 14'h0000};
          end
          3'd3: acc_d = acc_q + {2'b00, sym.value, 8'h00};
          3'd4: acc_d = acc_q + {8'h00, sym.value, 2'b00};
          3'd5: begin
            emit  = 1'b1;
            unit  = acc_q + {14'h0000, sym.value[5:4]};
            acc_d = {sym.value[3:0], 12'h000};
          end
          3'd6: acc_d = acc_q + {4'h0, sym.value, 6'h00};
          default: begin
            emit  = 1'b1;
            unit  = acc_q + {10'h000, sym.value};
            acc_d = '0;
          end
        endcase
      end
    end
    if (take_direct) begin
      if (s0_byte_q == {1'b0, escape_char_q}) begin
        in_b64_d = 1'b1;
        fresh_d  = 1'b1;
        step_d   = '0;
        acc_d    = '0;
      end else begin
        emit = 1'b1;
        unit = {{(UnitW-ByteW){1'b0}}, s0_byte_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_b64_q <= 1'b0;
      fresh_q  <= 1'b0;
      step_q   <= '0;
      acc_q    <= '0;
    end else if (fire) begin
      in_b64_q <= in_b64_d;
      fresh_q  <= fresh_d;
      step_q   <= step_d;
      acc_q    <= acc_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_unit_q <= unit;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.code_unit = out_unit_q;

endmodule

`default_nettype wire

[src/utf7_symbol_lookup.sv]
`default_nettype none

module utf7_symbol_lookup import utf7_pkg::*; (
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic [CharW-1:0] last_char_i,
  output sym_t                  sym_o
);

  logic [ByteW-1:0] upper_off;
  logic [ByteW-1:0] lower_off;
  logic [ByteW-1:0] digit_off;

  assign upper_off = byte_i - UpperA;
  assign lower_off = byte_i - LowerA;
  assign digit_off = byte_i - Digit0;

  // Ranges are tested in priority order, so a last character that is already
  // a letter, digit or plus keeps its ordinary value.
  always_comb begin
    sym_o.valid = 1'b1;
    sym_o.value = '0;
    if (byte_i >= UpperA && byte_i <= UpperZ) begin
      sym_o.value = upper_off[SymW-1:0];
    end else if (byte_i >= LowerA && byte_i <= LowerZ) begin
      sym_o.value = LowerBase + lower_off[SymW-1:0];
    end else if (byte_i >= Digit0 && byte_i <= Digit9) begin
      sym_o.value = DigitBase + digit_off[SymW-1:0];
    end else if (byte_i == PlusChar) begin
      sym_o.value = PlusValue;
    end else if (byte_i == {1'b0, last_char_i}) begin
      sym_o.value = LastValue;
    end else begin
      sym_o.valid = 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/utf7_checker.sv]
`default_nettype none

module utf7_checker import utf7_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic [ByteW-1:0] in_byte_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [UnitW-1:0] code_unit_i
);

  logic in_accept;

  assign in_accept = in_valid_i && in_ready_i;

  // A waiting code unit stays offered until the request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("code unit dropped while stalled");

  // With the result register empty the input side must not stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // A byte above the 7-bit range is never a symbol or an escape, so it always comes
  // out unchanged via the input register and then the free result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_byte_i[7] ##1 !out_valid_i |=>
      out_valid_i && code_unit_i[15:8] == 8'h00 && code_unit_i[7:0] == $past(in_byte_i, 2))
    else $error("high byte not passed through");

  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result offered right after reset");

endmodule

bind utf7_decoder_unit utf7_checker u_utf7_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_byte_i   (in_i.in_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .code_unit_i (out_o.code_unit)
);

`default_nettype wire
